FILE: rtl/swq_pkg.sv
// Shared types and constants for the semaphore wait-queue table.
package swq_pkg;

	localparam int MAX_PROCS_DEF = 32;
	localparam int KEY_BITS_DEF  = 32;

	typedef enum logic [1:0] {
		CMD_BLOCK  = 2'd0,
		CMD_WAKE   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_PEEK   = 2'd3
	} cmd_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NULL     = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_BLOCKED  = 3'd4;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] sem_key;
		logic [4:0]  proc_id;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] result_proc;
		logic       result_valid;
	} rsp_t;

	// Decoded command handed from the front end to the back end
	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] key;
		logic [4:0]  proc;
		logic        key_null;
		logic        proc_bad;
	} op_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SEARCH,
		B_DECIDE,
		B_APPEND,
		B_APPEND2,
		B_HEAD,
		B_UNLINK
	} back_state_t;

endpackage

FILE: rtl/semaphore_wait_queue_table.sv
// Semaphore wait-queue table: descriptor pool with per-key FIFOs of blocked processes.
//
// Requests (req_valid/req_ready, req) carry command, sem_key and proc_id; every
// request yields exactly one response (rsp_valid/rsp_ready, rsp) with status,
// result_proc and result_valid, in request order.
// The front end registers and classifies a request and hands it to a
// two-entry queue; the back end sequencer then executes it against the tables.
// The back end ends a rejected command or a block on a new key in B_DECIDE,
// a peek in B_HEAD, a remove in B_UNLINK, a block on an existing key in
// B_APPEND then B_APPEND2, and a wake in B_HEAD then B_UNLINK. These steps follow
// from the key search and the registered reads of the queue tables.
// The front end keeps taking requests while a response waits; once the queue
// fills, req_ready drops. The back end starts a new command only when the
// response register is free or being taken, so a stalled receiver holds the
// pipeline without loss.
// Reset frees every descriptor and clears every blocked mark; requests are
// accepted from the first cycle after reset.
module semaphore_wait_queue_table import swq_pkg::*; #(
	parameter int MAX_PROCS = MAX_PROCS_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic fr_valid, fr_ready;
	op_t  fr_op;
	logic bk_valid, bk_ready;
	op_t  bk_op;

	swq_front #(
		.MAX_PROCS(MAX_PROCS),
		.KEY_BITS (KEY_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.op_valid (fr_valid),
		.op_ready (fr_ready),
		.op       (fr_op)
	);

	swq_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fr_valid),
		.push_ready(fr_ready),
		.push_op   (fr_op),
		.pop_valid (bk_valid),
		.pop_ready (bk_ready),
		.pop_op    (bk_op)
	);

	swq_back #(
		.MAX_PROCS(MAX_PROCS),
		.KEY_BITS (KEY_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (bk_valid),
		.op_ready (bk_ready),
		.op       (bk_op),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

`ifndef ASSERT_OFF
	a_proc_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_valid |-> rsp.status == ST_OK)
		else $error("process returned with error status");

	a_no_proc_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.result_valid |-> rsp.result_proc == 5'd0)
		else $error("nonzero process id without a process");

	a_no_start_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !bk_ready)
		else $error("back end started while a response is stalled");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		bk_ready |-> bk_valid)
		else $error("back end took a command from an empty queue");
`endif

endmodule

FILE: rtl/swq_front.sv
// Front end: takes request transactions, masks the key and classifies them.
module swq_front import swq_pkg::*; #(
	parameter int MAX_PROCS = MAX_PROCS_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic op_valid,
	input  logic op_ready,
	output op_t  op
);

	localparam logic [31:0] KeyMask =
		(KEY_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << KEY_BITS) - 64'd1);

	logic valid_q;
	op_t  op_q;
	logic [31:0] key_m;

	assign key_m     = req.sem_key & KeyMask;
	assign req_ready = !valid_q || op_ready;
	assign op_valid  = valid_q;
	assign op        = op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req_ready) begin
			valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q.cmd      <= cmd_t'(req.command);
			op_q.key      <= key_m;
			op_q.proc     <= req.proc_id;
			op_q.key_null <= (key_m == 32'd0);
			op_q.proc_bad <= ({27'd0, req.proc_id} >= 32'(MAX_PROCS));
		end
	end

endmodule

FILE: rtl/swq_fifo.sv
// Two-entry queue between the front end and the back end.
module swq_fifo import swq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  op_t  push_op,
	output logic pop_valid,
	input  logic pop_ready,
	output op_t  pop_op
);

	op_t        mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_op     = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_op;
	end

endmodule

FILE: rtl/swq_back.sv
// Back end: descriptor search, linked wait queues and the response register.
module swq_back import swq_pkg::*; #(
	parameter int MAX_PROCS = MAX_PROCS_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_ready,
	input  op_t  op,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// Only 32 process ids exist, so no more descriptors than that can be live
	localparam int NP = (MAX_PROCS < 32) ? MAX_PROCS : 32;
	localparam int IW = (NP > 1) ? $clog2(NP) : 1;

	typedef logic [IW-1:0] idx_t;

	function automatic idx_t first_one(input logic [NP-1:0] v);
		idx_t r;
		r = '0;
		for (int i = NP - 1; i >= 0; i--) begin
			if (v[i]) r = IW'(i);
		end
		return r;
	endfunction

	back_state_t state_q, state_d;
	op_t         cur_q;

	logic [KEY_BITS-1:0] slot_key_q [NP];
	logic [NP-1:0]       slot_active_q;
	logic [NP-1:0]       proc_blocked_q;

	idx_t head_mem [NP];
	idx_t tail_mem [NP];
	idx_t next_mem [NP];
	idx_t prev_mem [NP];
	idx_t pslot_mem [NP];

	idx_t head_rd_q, tail_rd_q, next_rd_q, prev_rd_q, pslot_rd_q;
	logic [NP-1:0] hit_q, free_q;
	logic          blocked_q;
	idx_t          us_q, u_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic [KEY_BITS-1:0] key_ext;
	logic [NP-1:0]       hit_d;
	idx_t cur_p, hit_s, free_s;
	logic found, has_free;

	idx_t ra_slot, ra_proc;
	logic we_head, we_tail, we_next, we_prev, we_pslot;
	idx_t wa_head, wa_tail, wa_next, wa_prev, wa_pslot;
	idx_t wd_head, wd_tail, wd_next, wd_prev, wd_pslot;
	logic new_slot, slot_clr, blk_set, blk_clr;
	idx_t nxt_us, nxt_u;
	logic done;
	logic [2:0] d_status;
	logic [4:0] d_proc;
	logic d_rv;
	logic is_head, is_tail;

	assign key_ext  = KEY_BITS'(cur_q.key);
	assign cur_p    = cur_q.proc[IW-1:0];
	assign hit_s    = first_one(hit_q);
	assign free_s   = first_one(free_q);
	assign found    = |hit_q;
	assign has_free = |free_q;
	assign is_head  = (head_rd_q == u_q);
	assign is_tail  = (tail_rd_q == u_q);

	always_comb begin
		for (int i = 0; i < NP; i++) begin
			hit_d[i] = slot_active_q[i] && (slot_key_q[i] == key_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op_ready = 1'b0;
		ra_slot  = us_q;
		ra_proc  = cur_p;
		we_head  = 1'b0; wa_head  = us_q;  wd_head  = cur_p;
		we_tail  = 1'b0; wa_tail  = us_q;  wd_tail  = cur_p;
		we_next  = 1'b0; wa_next  = cur_p; wd_next  = cur_p;
		we_prev  = 1'b0; wa_prev  = cur_p; wd_prev  = cur_p;
		we_pslot = 1'b0; wa_pslot = cur_p; wd_pslot = us_q;
		new_slot = 1'b0;
		slot_clr = 1'b0;
		blk_set  = 1'b0;
		blk_clr  = 1'b0;
		nxt_us   = us_q;
		nxt_u    = u_q;
		done     = 1'b0;
		d_status = ST_OK;
		d_proc   = 5'd0;
		d_rv     = 1'b0;
		case (state_q)
			B_IDLE: begin
				// start only when the response register is free at completion
				if (op_valid && (!rsp_valid_q || rsp_ready)) begin
					op_ready = 1'b1;
					state_d  = B_SEARCH;
				end
			end
			B_SEARCH: begin
				ra_proc = cur_p;
				state_d = B_DECIDE;
			end
			B_DECIDE: begin
				case (cur_q.cmd)
					CMD_BLOCK: begin
						if (cur_q.key_null) begin
							done = 1'b1; d_status = ST_NULL;
						end else if (cur_q.proc_bad) begin
							done = 1'b1; d_status = ST_NOTFOUND;
						end else if (blocked_q) begin
							done = 1'b1; d_status = ST_BLOCKED;
						end else if (found) begin
							ra_slot = hit_s;
							nxt_us  = hit_s;
							state_d = B_APPEND;
						end else if (!has_free) begin
							done = 1'b1; d_status = ST_FULL;
						end else begin
							new_slot = 1'b1;
							nxt_us   = free_s;
							we_head  = 1'b1; wa_head = free_s;
							we_tail  = 1'b1; wa_tail = free_s;
							we_next  = 1'b1;
							we_prev  = 1'b1;
							we_pslot = 1'b1; wd_pslot = free_s;
							blk_set  = 1'b1;
							done     = 1'b1;
						end
					end
					CMD_WAKE, CMD_PEEK: begin
						if (cur_q.key_null) begin
							done = 1'b1; d_status = ST_NULL;
						end else if (!found) begin
							done = 1'b1; d_status = ST_NOTFOUND;
						end else begin
							ra_slot = hit_s;
							nxt_us  = hit_s;
							state_d = B_HEAD;
						end
					end
					CMD_REMOVE: begin
						if (cur_q.proc_bad || !blocked_q) begin
							done = 1'b1; d_status = ST_NOTFOUND;
						end else begin
							ra_slot = pslot_rd_q;
							ra_proc = cur_p;
							nxt_us  = pslot_rd_q;
							nxt_u   = cur_p;
							state_d = B_UNLINK;
						end
					end
					default: begin
						done = 1'b1;
					end
				endcase
			end
			B_APPEND: begin
				we_next = 1'b1; wa_next = tail_rd_q; wd_next = cur_p;
				we_prev = 1'b1; wa_prev = cur_p;     wd_prev = tail_rd_q;
				we_tail = 1'b1; wa_tail = us_q;      wd_tail = cur_p;
				state_d = B_APPEND2;
			end
			B_APPEND2: begin
				we_next  = 1'b1;
				we_pslot = 1'b1;
				blk_set  = 1'b1;
				done     = 1'b1;
			end
			B_HEAD: begin
				if (cur_q.cmd == CMD_PEEK) begin
					done   = 1'b1;
					d_proc = 5'(head_rd_q);
					d_rv   = 1'b1;
				end else begin
					ra_slot = us_q;
					ra_proc = head_rd_q;
					nxt_u   = head_rd_q;
					state_d = B_UNLINK;
				end
			end
			B_UNLINK: begin
				if (is_head && is_tail) begin
					slot_clr = 1'b1;
				end else begin
					if (is_head) begin
						we_head = 1'b1; wa_head = us_q; wd_head = next_rd_q;
					end else begin
						we_next = 1'b1; wa_next = prev_rd_q; wd_next = next_rd_q;
					end
					if (is_tail) begin
						we_tail = 1'b1; wa_tail = us_q; wd_tail = prev_rd_q;
					end else begin
						we_prev = 1'b1; wa_prev = next_rd_q; wd_prev = prev_rd_q;
					end
				end
				blk_clr = 1'b1;
				done    = 1'b1;
				d_proc  = 5'(u_q);
				d_rv    = 1'b1;
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
		if (done) state_d = B_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_active_q  <= '0;
			proc_blocked_q <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (new_slot) slot_active_q[free_s] <= 1'b1;
			if (slot_clr) slot_active_q[us_q] <= 1'b0;
			if (blk_set) proc_blocked_q[cur_p] <= 1'b1;
			if (blk_clr) proc_blocked_q[u_q] <= 1'b0;
			if (done) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op_ready) cur_q <= op;
		if (state_q == B_SEARCH) begin
			hit_q     <= hit_d;
			free_q    <= ~slot_active_q;
			blocked_q <= proc_blocked_q[cur_p];
		end
		if (new_slot) slot_key_q[free_s] <= key_ext;
		us_q <= nxt_us;
		u_q  <= nxt_u;
		if (done) begin
			rsp_q.status       <= d_status;
			rsp_q.result_proc  <= d_proc;
			rsp_q.result_valid <= d_rv;
		end
	end

	// Queue memories: one write and one registered read per array each cycle
	always_ff @(posedge clk) begin
		if (we_head) head_mem[wa_head] <= wd_head;
		if (we_tail) tail_mem[wa_tail] <= wd_tail;
		if (we_next) next_mem[wa_next] <= wd_next;
		if (we_prev) prev_mem[wa_prev] <= wd_prev;
		if (we_pslot) pslot_mem[wa_pslot] <= wd_pslot;
		head_rd_q  <= head_mem[ra_slot];
		tail_rd_q  <= tail_mem[ra_slot];
		next_rd_q  <= next_mem[ra_proc];
		prev_rd_q  <= prev_mem[ra_proc];
		pslot_rd_q <= pslot_mem[ra_proc];
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the semaphore wait-queue table.
module tb_top;
	import swq_pkg::*;

	localparam int NPROC = MAX_PROCS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	semaphore_wait_queue_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// Shadow copy of the descriptor pool and wait queues
	logic [31:0] sh_key [NPROC];
	logic        sh_active [NPROC];
	logic [4:0]  sh_head [NPROC];
	logic [4:0]  sh_tail [NPROC];
	logic [4:0]  sh_next [NPROC];
	logic [4:0]  sh_prev [NPROC];
	logic        sh_blocked [NPROC];
	logic [4:0]  sh_slot [NPROC];

	rsp_t pending_rsp [$];
	int   errors;
	int   n_sent, n_checked, n_full, n_woken;
	int   idle_cycles;
	logic [31:0] key_pool [8];

	initial begin
		clk = 1'b0;
	end
	always #10 clk = ~clk;

	function automatic int lookup_slot(logic [31:0] key);
		for (int s = 0; s < NPROC; s++)
			if (sh_active[s] && sh_key[s] == key)
				return s;
		return NPROC;
	endfunction

	function automatic void dequeue_proc(int p);
		int  s, pr, nx;
		logic at_head, at_tail;
		s = sh_slot[p];
		pr = sh_prev[p];
		nx = sh_next[p];
		at_head = (sh_head[s] == p);
		at_tail = (sh_tail[s] == p);
		if (at_head && at_tail) begin
			sh_active[s] = 1'b0;
		end else begin
			if (at_head) sh_head[s] = 5'(nx);
			else sh_next[pr] = 5'(nx);
			if (at_tail) sh_tail[s] = 5'(pr);
			else sh_prev[nx] = 5'(pr);
		end
		sh_blocked[p] = 1'b0;
	endfunction

	function automatic rsp_t table_update(req_t r);
		rsp_t o;
		int s, t, p;
		o = '0;
		o.status = ST_OK;
		p = r.proc_id;
		case (cmd_t'(r.command))
			CMD_BLOCK: begin
				if (r.sem_key == '0) o.status = ST_NULL;
				else if (sh_blocked[p]) o.status = ST_BLOCKED;
				else begin
					s = lookup_slot(r.sem_key);
					if (s == NPROC) begin
						for (s = 0; s < NPROC; s++)
							if (!sh_active[s]) break;
						if (s == NPROC) o.status = ST_FULL;
						else begin
							sh_active[s] = 1'b1;
							sh_key[s] = r.sem_key;
							sh_head[s] = 5'(p);
							sh_tail[s] = 5'(p);
							sh_next[p] = 5'(p);
							sh_prev[p] = 5'(p);
						end
					end else begin
						t = sh_tail[s];
						sh_next[t] = 5'(p);
						sh_prev[p] = 5'(t);
						sh_next[p] = 5'(p);
						sh_tail[s] = 5'(p);
					end
					if (o.status == ST_OK) begin
						sh_blocked[p] = 1'b1;
						sh_slot[p] = 5'(s);
					end
				end
			end
			CMD_WAKE, CMD_PEEK: begin
				if (r.sem_key == '0) o.status = ST_NULL;
				else begin
					s = lookup_slot(r.sem_key);
					if (s == NPROC) o.status = ST_NOTFOUND;
					else begin
						o.result_proc = sh_head[s];
						o.result_valid = 1'b1;
						if (cmd_t'(r.command) == CMD_WAKE)
							dequeue_proc(sh_head[s]);
					end
				end
			end
			default: begin
				if (!sh_blocked[p]) o.status = ST_NOTFOUND;
				else begin
					dequeue_proc(p);
					o.result_proc = r.proc_id;
					o.result_valid = 1'b1;
				end
			end
		endcase
		return o;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Sends one transaction; the expectation is formed at acceptance
	task automatic send_cmd(cmd_t c, logic [31:0] key, logic [4:0] p);
		rsp_t e;
		req_t r;
		r.command = c;
		r.sem_key = key;
		r.proc_id = p;
		repeat (gap_len()) @(negedge clk);
		req_valid = 1'b1;
		req = r;
		do @(posedge clk); while (!req_ready);
		e = table_update(r);
		if (e.status == ST_FULL) n_full++;
		if (c == CMD_WAKE && e.result_valid) n_woken++;
		pending_rsp.push_back(e);
		n_sent++;
		@(negedge clk);
		req_valid = 1'b0;
	endtask

	task automatic drain_queue();
		while (pending_rsp.size() != 0) @(negedge clk);
	endtask

	// Response checker
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			n_checked++;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response %p", $time, rsp);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.status !== e.status || rsp.result_proc !== e.result_proc ||
				    rsp.result_valid !== e.result_valid) begin
					$display("%0t: mismatch expected %p actual %p", $time, e, rsp);
					errors++;
				end
			end
		end
	end

	// Receiver stalls
	initial begin
		int n;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rsp_ready <= 1'b1;
			n = $urandom_range(0, 3) == 0 ? gap_len() : 0;
			if (n > 0) begin
				@(negedge clk);
				rsp_ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	// Watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("%0t: watchdog timeout", $time);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic test_null_and_unknown();
		send_cmd(CMD_BLOCK, 32'h0, 5'd0);
		send_cmd(CMD_WAKE, 32'h0, 5'd3);
		send_cmd(CMD_PEEK, 32'h0, 5'd31);
		send_cmd(CMD_WAKE, 32'hFFFF_FFFF, 5'd0);
		send_cmd(CMD_PEEK, 32'h1, 5'd0);
		send_cmd(CMD_REMOVE, 32'h0, 5'd7);
	endtask

	task automatic test_fifo_order();
		send_cmd(CMD_BLOCK, 32'hFFFF_FFFF, 5'd31);
		send_cmd(CMD_BLOCK, 32'hFFFF_FFFF, 5'd0);
		send_cmd(CMD_BLOCK, 32'hFFFF_FFFF, 5'd5);
		send_cmd(CMD_BLOCK, 32'h1, 5'd0);  // already blocked
		send_cmd(CMD_PEEK, 32'hFFFF_FFFF, 5'd0);
		send_cmd(CMD_REMOVE, 32'h0, 5'd0);  // middle of queue
		send_cmd(CMD_WAKE, 32'hFFFF_FFFF, 5'd0);
		send_cmd(CMD_WAKE, 32'hFFFF_FFFF, 5'd0);
		send_cmd(CMD_WAKE, 32'hFFFF_FFFF, 5'd0);  // descriptor already freed, key not found
		send_cmd(CMD_REMOVE, 32'h0, 5'd31);
	endtask

	// Every process on its own key uses the whole pool
	task automatic test_pool_exhausted();
		for (int p = 0; p < NPROC; p++)
			send_cmd(CMD_BLOCK, 32'h100 + p, p[4:0]);
		drain_queue();
		send_cmd(CMD_REMOVE, 32'h0, 5'd9);
		send_cmd(CMD_BLOCK, 32'h1234_5678, 5'd9);
		send_cmd(CMD_BLOCK, 32'h8000_0000, 5'd9);  // already blocked, every descriptor in use
		for (int p = 0; p < NPROC; p++)
			send_cmd(CMD_REMOVE, 32'h0, p[4:0]);
	endtask

	task automatic test_random(int count);
		cmd_t c;
		logic [31:0] key;
		int r;
		for (int i = 0; i < 8; i++) key_pool[i] = $urandom() | 32'h1;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40) c = CMD_BLOCK;
			else if (r < 65) c = CMD_WAKE;
			else if (r < 85) c = CMD_REMOVE;
			else c = CMD_PEEK;
			r = $urandom_range(0, 99);
			if (r < 80) key = key_pool[$urandom_range(0, 7)];
			else if (r < 85) key = 32'h0;
			else key = $urandom();
			send_cmd(c, key, 5'($urandom_range(0, NPROC - 1)));
			if (i == count / 2) drain_queue();
		end
	endtask

	initial begin
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_full = 0;
		n_woken = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		for (int i = 0; i < NPROC; i++) begin
			sh_active[i] = 1'b0;
			sh_blocked[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_null_and_unknown();
		test_fifo_order();
		test_pool_exhausted();
		test_random(560);
		drain_queue();
		repeat (20) @(negedge clk);
		$display("Sent %0d commands, checked %0d responses", n_sent, n_checked);
		$display("Pool-full rejections %0d, successful wakes %0d", n_full, n_woken);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
